// ===== rtl/fdb_pkg.sv =====
// ---------------------------------------------------------------------------
// fdb_pkg
// Shared types and constants for the forwarding database table engine.
// ---------------------------------------------------------------------------
package fdb_pkg;

	localparam int unsigned TableDepthDefault = 256;
	localparam int unsigned MacWidth   = 48;
	localparam int unsigned IdWidth    = 64;
	localparam int unsigned CountWidth = 9;
	localparam int unsigned QueueDepth = 2;

	typedef enum logic [1:0] {
		MODE_LEARN = 2'd0,
		MODE_AGED  = 2'd1,
		MODE_MOVE  = 2'd2,
		MODE_FLUSH = 2'd3
	} mode_t;

	// classified command handed from front to back
	typedef struct packed {
		mode_t                mode;
		logic                 flush_all;
		logic                 vlan_zero;
		logic                 port_zero;
		logic [MacWidth-1:0]  mac;
		logic [IdWidth-1:0]   vlan;
		logic [IdWidth-1:0]   port;
	} cmd_t;

endpackage

// ===== rtl/fdb_front.sv =====
// ---------------------------------------------------------------------------
// fdb_front
// Accepts events, classifies flush wildcards, and queues commands.
// ---------------------------------------------------------------------------
module fdb_front
	import fdb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          mode,
	input  logic [MacWidth-1:0] mac_addr,
	input  logic [IdWidth-1:0]  bridge_vlan_id,
	input  logic [IdWidth-1:0]  bridge_port_id,
	output logic                cmd_valid,
	output cmd_t                cmd,
	input  logic                cmd_take
);

	localparam int unsigned PtrW = $clog2(QueueDepth);

	cmd_t              fifo_q [QueueDepth];
	logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PtrW:0]     cnt_q;
	cmd_t              cmd_in;
	logic              do_push, do_pop;

	always_comb begin
		cmd_in.mode      = mode_t'(mode);
		cmd_in.vlan_zero = (bridge_vlan_id == '0);
		cmd_in.port_zero = (bridge_port_id == '0);
		cmd_in.flush_all = cmd_in.vlan_zero && cmd_in.port_zero;
		cmd_in.mac       = mac_addr;
		cmd_in.vlan      = bridge_vlan_id;
		cmd_in.port      = bridge_port_id;
	end

	assign full      = (cnt_q == (PtrW+1)'(QueueDepth));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
		end
	end

endmodule

// ===== rtl/fdb_back.sv =====
// ---------------------------------------------------------------------------
// fdb_back
// Scans the table entry by entry (read, then compare and write back) to
// carry out a command; holds the result in an output register.
// ---------------------------------------------------------------------------
module fdb_back
	import fdb_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  cmd_t                  cmd,
	output logic                  cmd_take,
	output logic                  empty,
	input  logic                  pop,
	output logic                  status,
	output logic [CountWidth-1:0] entry_count
);

	localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_DONE
	} state_t;

	// entry payload memory; valid bits live in flops
	logic [MacWidth-1:0] mac_mem  [TABLE_DEPTH];
	logic [IdWidth-1:0]  vlan_mem [TABLE_DEPTH];
	logic [IdWidth-1:0]  port_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [IdxW-1:0]     idx_q;
	logic [CntW-1:0]     count_q;
	logic                placed_q;
	logic                out_full_q;
	logic                status_q;
	logic [CountWidth-1:0] count_out_q;

	logic [MacWidth-1:0] rd_mac_q;
	logic [IdWidth-1:0]  rd_vlan_q, rd_port_q;
	logic                rd_valid_q;

	logic                mem_we;
	logic                port_we;
	logic                res_load;
	logic                vm, pm, hit, last;

	assign vm   = (rd_vlan_q == cmd_q.vlan);
	assign pm   = (rd_port_q == cmd_q.port);
	assign last = (idx_q == IdxW'(TABLE_DEPTH - 1));

	always_comb begin
		case (cmd_q.mode)
			MODE_AGED, MODE_MOVE: hit = rd_valid_q && vm && (rd_mac_q == cmd_q.mac);
			MODE_FLUSH: hit = rd_valid_q && (cmd_q.flush_all || (cmd_q.port_zero && vm) ||
				(cmd_q.vlan_zero && pm) || (vm && pm));
			default: hit = 1'b0;
		endcase
	end

	assign mem_we  = (state_q == ST_EVAL) && (cmd_q.mode == MODE_LEARN) && !rd_valid_q
		&& !placed_q;
	assign port_we = (state_q == ST_EVAL) && (cmd_q.mode == MODE_MOVE) && hit;
	// a waiting result may be popped and replaced in the same cycle
	assign res_load = (state_q == ST_DONE) && (!out_full_q || pop);

	assign cmd_take    = (state_q == ST_IDLE) && cmd_valid;
	assign empty       = !out_full_q;
	assign status      = status_q;
	assign entry_count = count_out_q;

	always_ff @(posedge clk) begin
		rd_mac_q  <= mac_mem[idx_q];
		rd_vlan_q <= vlan_mem[idx_q];
		rd_port_q <= port_mem[idx_q];
		if (mem_we) begin
			mac_mem[idx_q]  <= cmd_q.mac;
			vlan_mem[idx_q] <= cmd_q.vlan;
		end
		if (mem_we || port_we) begin
			port_mem[idx_q] <= cmd_q.port;
		end
		if (cmd_take) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			idx_q       <= '0;
			count_q     <= '0;
			placed_q    <= 1'b0;
			out_full_q  <= 1'b0;
			status_q    <= 1'b0;
			count_out_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (res_load) begin
				out_full_q <= 1'b1;
			end else if (pop && out_full_q) begin
				out_full_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						idx_q    <= '0;
						placed_q <= 1'b0;
						state_q  <= ST_READ;
					end
				end
				ST_READ: begin
					rd_valid_q <= valid_q[idx_q];
					state_q    <= ST_EVAL;
				end
				ST_EVAL: begin
					if (mem_we) begin
						valid_q[idx_q] <= 1'b1;
						count_q        <= count_q + 1'b1;
						placed_q       <= 1'b1;
					end else if (hit && cmd_q.mode != MODE_MOVE) begin
						valid_q[idx_q] <= 1'b0;
						count_q        <= count_q - 1'b1;
					end
					// learn stops at the first free slot
					if (last || mem_we) begin
						state_q <= ST_DONE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						status_q    <= (cmd_q.mode == MODE_LEARN) && !placed_q;
						count_out_q <= CountWidth'(count_q);
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/fdb_shadow_table_engine.sv =====
// ---------------------------------------------------------------------------
// fdb_shadow_table_engine
// MAC forwarding table: learn, age, move and flush events, one result each.
// ---------------------------------------------------------------------------
// Input side is a queue: drive push with mode, mac_addr, bridge_vlan_id
// and bridge_port_id; the item is taken when push is high and full is low.
// A two-entry command queue decouples intake from the table scan.
// Result side is a queue: while empty is low, status and entry_count show
// the oldest result; pop takes it. status is 1 when a learn found no room.
// Each event walks the table entry by entry (memory read, then
// compare and write back); aged, move, flush and a dropped learn visit
// every entry, a learn stops at its free slot, and the back end takes no
// new event until the result of the last one is loaded.
// Reset clears every valid bit and the count at once; payload memory is
// not cleared. A stalled result holds the back end after its scan; the
// front queue keeps taking items until it fills, then full rises.
// ---------------------------------------------------------------------------
module fdb_shadow_table_engine
	import fdb_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [1:0]            mode,
	input  logic [MacWidth-1:0]   mac_addr,
	input  logic [IdWidth-1:0]    bridge_vlan_id,
	input  logic [IdWidth-1:0]    bridge_port_id,
	output logic                  empty,
	input  logic                  pop,
	output logic                  status,
	output logic [CountWidth-1:0] entry_count
);

	logic cmd_valid, cmd_take;
	cmd_t cmd;

	fdb_front u_front (
		.clk, .arst_n, .push, .full, .mode, .mac_addr,
		.bridge_vlan_id, .bridge_port_id, .cmd_valid, .cmd, .cmd_take
	);

	fdb_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd, .cmd_take, .empty, .pop,
		.status, .entry_count
	);

endmodule
